FILE: rtl/core/winograd_input_tile_transform_top_defines.svh
// Assertion macros shared by the Winograd input transform RTL.
`ifndef WINOGRAD_INPUT_TILE_TRANSFORM_TOP_DEFINES_SVH
`define WINOGRAD_INPUT_TILE_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define WIT_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define WIT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/core/wit_pkg.sv
// Package with shared constants and types of the Winograd input transform.
package wit_pkg;

    localparam int TILE         = 6;
    localparam int ROW_IDX_BITS = 3;
    localparam logic [ROW_IDX_BITS-1:0] LAST_ROW = ROW_IDX_BITS'(TILE - 1);

    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_RESULT_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 14;

    // The square root of two with 30 fraction bits.
    localparam logic [63:0] SQRT2_Q30 = 64'd1518500250;

    typedef struct packed {
        logic                    load;
        logic [ROW_IDX_BITS-1:0] idx;
    } merge_ctrl_t;

endpackage

FILE: rtl/core/wit_bt_pass.sv
// Multiplication of six values by the transform matrix, in modular fixed point.
module wit_bt_pass #(
    parameter int W_IN           = 16,
    parameter int W_OUT          = 35,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic [wit_pkg::TILE-1:0][W_IN-1:0]  x,
    output logic [wit_pkg::TILE-1:0][W_OUT-1:0] y
);
    import wit_pkg::*;

    localparam logic [63:0] SQ64 =
        (SQRT2_Q30 + (64'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS);
    localparam logic [W_OUT-1:0] K_S    = W_OUT'(SQ64);
    localparam logic [W_OUT-1:0] K_2S   = W_OUT'(SQ64 << 1);
    localparam logic [W_OUT-1:0] K_ONE  = W_OUT'(64'd1 << (COEF_FRAC_BITS + 1));
    localparam logic [W_OUT-1:0] K_HALF = W_OUT'(64'd1 << COEF_FRAC_BITS);
    localparam logic [W_OUT-1:0] K_TWO  = W_OUT'(64'd1 << (COEF_FRAC_BITS + 2));
    localparam logic [W_OUT-1:0] K_5H   = W_OUT'(64'd5 << COEF_FRAC_BITS);

    logic [W_OUT-1:0] xe [TILE];
    logic [W_OUT-1:0] sa;
    logic [W_OUT-1:0] sb;
    logic [W_OUT-1:0] sc;
    logic [W_OUT-1:0] sd;

    always_comb
    begin
        for (int k = 0; k < TILE; k++)
        begin
            xe[k] = W_OUT'($signed(x[k]));
        end
        sa = K_S * xe[3] - K_2S * xe[1];
        sb = K_ONE * xe[4] - K_TWO * xe[2];
        sc = K_2S * xe[3] - K_S * xe[1];
        sd = K_ONE * xe[4] - K_HALF * xe[2];
        y[0] = K_ONE * xe[0] - K_5H * xe[2] + K_ONE * xe[4];
        y[1] = sb + sa;
        y[2] = sb - sa;
        y[3] = sd + sc;
        y[4] = sd - sc;
        y[5] = K_ONE * xe[1] - K_5H * xe[3] + K_ONE * xe[5];
    end

endmodule

FILE: rtl/core/wit_lane.sv
// One column lane: holds a tile column of row-pass results and runs its column pass.
module wit_lane #(
    parameter int RW             = 35,
    parameter int CW             = 54,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [wit_pkg::ROW_IDX_BITS-1:0]     wr_idx,
    input  logic [RW-1:0]                        wr_data,
    input  logic                                 col_go,
    output logic [wit_pkg::TILE-1:0][CW-1:0]     res
);
    import wit_pkg::*;

    logic [RW-1:0]             col_reg [TILE];
    logic [TILE-1:0][RW-1:0]   col_vec;
    logic [TILE-1:0][CW-1:0]   res_next;
    logic [TILE-1:0][CW-1:0]   res_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            col_reg[wr_idx] <= wr_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < TILE; i++)
        begin
            col_vec[i] = col_reg[i];
        end
    end

    wit_bt_pass #(
        .W_IN           (RW),
        .W_OUT          (CW),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_col_pass (
        .x (col_vec),
        .y (res_next)
    );

    always_ff @(posedge clk)
    begin
        if (col_go)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: rtl/core/wit_merge.sv
// Merging stage: picks one result row from all lanes, rounds, saturates and registers it.
module wit_merge #(
    parameter int CW             = 54,
    parameter int RB             = 24,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  wit_pkg::merge_ctrl_t                               ctrl,
    input  logic [wit_pkg::TILE-1:0][wit_pkg::TILE-1:0][CW-1:0] res,
    output logic                                               free,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output logic [wit_pkg::TILE-1:0][RB-1:0]                   coef,
    output logic [wit_pkg::ROW_IDX_BITS-1:0]                   row_index,
    output logic                                               last_row
);
    import wit_pkg::*;

    localparam int DROP = 2 * (COEF_FRAC_BITS + 1);
    localparam int TW   = (CW + 1 > 64) ? 64 : CW + 1;
    localparam int SW   = (TW >= RB + 1) ? TW : RB + 1;

    localparam logic signed [TW-1:0] RND = TW'(64'sd1 <<< (DROP - 1));
    localparam logic signed [SW-1:0] HI  = SW'((64'sd1 <<< (RB - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] LO  = SW'(-(64'sd1 <<< (RB - 1)));

    logic signed [TW-1:0]        rnd_sum [TILE];
    logic signed [TW-1:0]        shifted [TILE];
    logic signed [SW-1:0]        wide    [TILE];
    logic [TILE-1:0][RB-1:0]     coef_next;

    logic                        valid_reg;
    logic [TILE-1:0][RB-1:0]     coef_reg;
    logic [ROW_IDX_BITS-1:0]     idx_reg;
    logic                        last_reg;

    always_comb
    begin
        for (int j = 0; j < TILE; j++)
        begin
            rnd_sum[j] = $signed(TW'($signed(res[j][ctrl.idx]))) + RND;
            shifted[j] = rnd_sum[j] >>> DROP;
            wide[j]    = SW'(shifted[j]);
            if (wide[j] > HI)
            begin
                coef_next[j] = HI[RB-1:0];
            end
            else if (wide[j] < LO)
            begin
                coef_next[j] = LO[RB-1:0];
            end
            else
            begin
                coef_next[j] = wide[j][RB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            coef_reg <= coef_next;
            idx_reg  <= ctrl.idx;
            last_reg <= (ctrl.idx == LAST_ROW);
        end
    end

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign coef      = coef_reg;
    assign row_index = idx_reg;
    assign last_row  = last_reg;

endmodule

FILE: rtl/core/winograd_input_tile_transform_top.sv
// Top level of the Winograd F(4x4,3x3) input tile transform.
//
// The input channel (in_valid, in_ready) takes one tile row of six samples per item,
// rows top to bottom. Each row goes through the horizontal pass as it is accepted,
// and its six results are written into six column lanes.
// Once the sixth row is in, the lanes run the column pass in the next cycle, and the
// merging stage then gives six result rows (row_index 0 to 5, last_row on the final
// one) through the output channel (out_valid, out_ready), at most one per cycle.
// The first result row goes valid after the lane column pass and the merge register.
// The first five rows of the next tile are taken while the results drain; its sixth
// row waits until the last result row of the previous tile is in the output register.
// With no stall on the output, the tile rate is set by the six-row drain of
// the merging stage plus the column pass.
// A stalled receiver holds the output register and, behind it, the drain.
// Reset clears the row count, the drain control and the output valid; the lane
// storage holds no defined value until a tile has been written.
`include "winograd_input_tile_transform_top_defines.svh"

module winograd_input_tile_transform_top #(
    parameter int SAMPLE_BITS    = wit_pkg::DEF_SAMPLE_BITS,
    parameter int RESULT_BITS    = wit_pkg::DEF_RESULT_BITS,
    parameter int COEF_FRAC_BITS = wit_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample_0,
    input  logic signed [SAMPLE_BITS-1:0]        sample_1,
    input  logic signed [SAMPLE_BITS-1:0]        sample_2,
    input  logic signed [SAMPLE_BITS-1:0]        sample_3,
    input  logic signed [SAMPLE_BITS-1:0]        sample_4,
    input  logic signed [SAMPLE_BITS-1:0]        sample_5,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [RESULT_BITS-1:0]        coef_0,
    output logic signed [RESULT_BITS-1:0]        coef_1,
    output logic signed [RESULT_BITS-1:0]        coef_2,
    output logic signed [RESULT_BITS-1:0]        coef_3,
    output logic signed [RESULT_BITS-1:0]        coef_4,
    output logic signed [RESULT_BITS-1:0]        coef_5,
    output logic [wit_pkg::ROW_IDX_BITS-1:0]     row_index,
    output logic                                 last_row
);
    import wit_pkg::*;

    localparam int RW_FULL = SAMPLE_BITS + COEF_FRAC_BITS + 5;
    localparam int RW      = (RW_FULL > 64) ? 64 : RW_FULL;
    localparam int CW_FULL = RW + COEF_FRAC_BITS + 5;
    localparam int CW      = (CW_FULL > 64) ? 64 : CW_FULL;

    logic [TILE-1:0][SAMPLE_BITS-1:0]      row_in;
    logic [TILE-1:0][RW-1:0]               row_out;
    logic [TILE-1:0][TILE-1:0][CW-1:0]     res_all;
    logic [TILE-1:0][RESULT_BITS-1:0]      coef;

    logic                                  in_acc;
    logic                                  merge_free;
    merge_ctrl_t                           merge_ctrl;

    logic [ROW_IDX_BITS-1:0]               rows_reg;
    logic [ROW_IDX_BITS-1:0]               rows_next;
    logic                                  col_go_reg;
    logic                                  col_go_next;
    logic                                  drain_active_reg;
    logic                                  drain_active_next;
    logic [ROW_IDX_BITS-1:0]               out_idx_reg;
    logic [ROW_IDX_BITS-1:0]               out_idx_next;

    assign row_in[0] = sample_0;
    assign row_in[1] = sample_1;
    assign row_in[2] = sample_2;
    assign row_in[3] = sample_3;
    assign row_in[4] = sample_4;
    assign row_in[5] = sample_5;

    assign in_ready = !((rows_reg == LAST_ROW) && (col_go_reg || drain_active_reg));
    assign in_acc   = in_valid && in_ready;

    wit_bt_pass #(
        .W_IN           (SAMPLE_BITS),
        .W_OUT          (RW),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_row_pass (
        .x (row_in),
        .y (row_out)
    );

    for (genvar j = 0; j < TILE; j++)
    begin : g_lane
        wit_lane #(
            .RW             (RW),
            .CW             (CW),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .wr_en   (in_acc),
            .wr_idx  (rows_reg),
            .wr_data (row_out[j]),
            .col_go  (col_go_reg),
            .res     (res_all[j])
        );
    end

    assign merge_ctrl.load = drain_active_reg && merge_free;
    assign merge_ctrl.idx  = out_idx_reg;

    wit_merge #(
        .CW             (CW),
        .RB             (RESULT_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (merge_ctrl),
        .res       (res_all),
        .free      (merge_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .coef      (coef),
        .row_index (row_index),
        .last_row  (last_row)
    );

    assign coef_0 = coef[0];
    assign coef_1 = coef[1];
    assign coef_2 = coef[2];
    assign coef_3 = coef[3];
    assign coef_4 = coef[4];
    assign coef_5 = coef[5];

    always_comb
    begin
        rows_next         = rows_reg;
        col_go_next       = 1'b0;
        drain_active_next = drain_active_reg;
        out_idx_next      = out_idx_reg;
        if (in_acc)
        begin
            if (rows_reg == LAST_ROW)
            begin
                rows_next   = '0;
                col_go_next = 1'b1;
            end
            else
            begin
                rows_next = rows_reg + 1'b1;
            end
        end
        if (col_go_reg)
        begin
            drain_active_next = 1'b1;
            out_idx_next      = '0;
        end
        else if (merge_ctrl.load)
        begin
            if (out_idx_reg == LAST_ROW)
            begin
                drain_active_next = 1'b0;
            end
            else
            begin
                out_idx_next = out_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg         <= '0;
            col_go_reg       <= 1'b0;
            drain_active_reg <= 1'b0;
            out_idx_reg      <= '0;
        end
        else
        begin
            rows_reg         <= rows_next;
            col_go_reg       <= col_go_next;
            drain_active_reg <= drain_active_next;
            out_idx_reg      <= out_idx_next;
        end
    end

    `WIT_ASSERT_SAME(a_rows_range, 1'b1, rows_reg <= LAST_ROW, "Row count out of range.")
    `WIT_ASSERT_SAME(a_col_go_idle, col_go_reg, !drain_active_reg, "Column pass during drain.")
    `WIT_ASSERT_NEXT(a_drain_start, col_go_reg, drain_active_reg && out_idx_reg == '0,
        "Drain did not start after the column pass.")
    `WIT_ASSERT_NEXT(a_drain_end, merge_ctrl.load && out_idx_reg == LAST_ROW,
        !drain_active_reg, "Drain did not stop after the last row.")
    `WIT_ASSERT_SAME(a_last_flag, out_valid, last_row == (row_index == LAST_ROW),
        "Last row flag does not match the row index.")

endmodule
